@@ hw/rtl/efr_pkg.sv @@
`timescale 1ns / 1ps

package efr_pkg;

  localparam int PACKET_BYTES = 256;
  localparam int POS_W = $clog2(PACKET_BYTES);

  localparam logic [POS_W-1:0] CRC_START_POS = POS_W'(PACKET_BYTES - 4);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);

  localparam logic [7:0] ESCAPE_RESET = 8'd126;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_position;
    logic packet_end;
    logic crc_match;
    logic [15:0] good_packets;
    logic [15:0] bad_packets;
  } result_t;

  // reflected crc-32, one byte lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/efr_deframer.sv @@
`timescale 1ns / 1ps

module efr_deframer (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [7:0] cfg_data,
  input  logic step,
  input  logic [7:0] rx_byte,
  output logic emit,
  output efr_pkg::result_t result
);

  logic [7:0] escape_code;
  logic escape_pending, escape_pending_next;
  logic [efr_pkg::POS_W-1:0] write_position, write_position_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] received_crc, received_crc_next;
  logic [15:0] good_count, good_count_next;
  logic [15:0] bad_count, bad_count_next;

  logic is_escape;
  logic restart;
  logic [efr_pkg::POS_W-1:0] pos;
  logic [31:0] crc_base;
  logic [31:0] rcv_base;
  logic [efr_pkg::POS_W-1:0] crc_offset;
  logic [31:0] rcv_merged;
  logic at_end;
  logic match;

  assign is_escape = (rx_byte == escape_code);
  assign restart = !is_escape && escape_pending;
  assign emit = !(is_escape && !escape_pending);

  // a restart clears the packet before this byte is stored
  assign pos = restart ? '0 : write_position;
  assign crc_base = restart ? efr_pkg::CRC_INIT : running_crc;
  assign rcv_base = restart ? 32'd0 : received_crc;
  assign crc_offset = pos - efr_pkg::CRC_START_POS;
  assign rcv_merged = rcv_base | ({24'd0, rx_byte} << {crc_offset[1:0], 3'b000});
  assign at_end = (pos >= efr_pkg::LAST_POS);
  // the last byte is always a crc byte, so the running crc is final here
  assign match = at_end && ((crc_base ^ efr_pkg::CRC_INIT) == rcv_merged);

  always_comb begin
    escape_pending_next = escape_pending;
    write_position_next = write_position;
    running_crc_next = crc_base;
    received_crc_next = rcv_base;
    good_count_next = good_count;
    bad_count_next = bad_count;
    if (is_escape && !escape_pending) begin
      escape_pending_next = 1'b1;
      running_crc_next = running_crc;
      received_crc_next = received_crc;
    end else begin
      escape_pending_next = 1'b0;
      if (pos < efr_pkg::CRC_START_POS) begin
        running_crc_next = efr_pkg::crc_byte(crc_base, rx_byte);
      end else begin
        received_crc_next = rcv_merged;
      end
      if (at_end) begin
        if (match) begin
          if (good_count != efr_pkg::COUNT_MAX) good_count_next = good_count + 16'd1;
        end else begin
          if (bad_count != efr_pkg::COUNT_MAX) bad_count_next = bad_count + 16'd1;
        end
      end
      write_position_next = at_end ? '0 : pos + 1'b1;
    end
  end

  always_comb begin
    result.data_byte = rx_byte;
    result.byte_position = 8'(pos);
    result.packet_end = at_end;
    result.crc_match = match;
    result.good_packets = good_count_next;
    result.bad_packets = bad_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_code <= efr_pkg::ESCAPE_RESET;
    end else if (cfg_write) begin
      escape_code <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      write_position <= '0;
      running_crc <= efr_pkg::CRC_INIT;
      received_crc <= 32'd0;
      good_count <= 16'd0;
      bad_count <= 16'd0;
    end else if (step) begin
      escape_pending <= escape_pending_next;
      // restart state after the last byte
      write_position <= write_position_next;
      running_crc <= at_end && emit ? efr_pkg::CRC_INIT : running_crc_next;
      received_crc <= at_end && emit ? 32'd0 : received_crc_next;
      good_count <= good_count_next;
      bad_count <= bad_count_next;
    end
  end

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    write_position <= efr_pkg::LAST_POS)
    else $error("write position past end of packet");

  a_end_wraps: assert property (@(posedge clk) disable iff (rst)
    step && emit && at_end |=> write_position == '0 && running_crc == efr_pkg::CRC_INIT)
    else $error("packet end did not restart packet");

  a_lone_escape_holds: assert property (@(posedge clk) disable iff (rst)
    step && !emit |=> escape_pending && $stable(write_position) && $stable(running_crc))
    else $error("lone escape changed packet state");

  a_counts_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    step |=> $countones({good_count != $past(good_count), bad_count != $past(bad_count)}) <= 1)
    else $error("both packet counters moved");

endmodule

@@ hw/rtl/escaped_frame_receiver_crc32_core.sv @@
`timescale 1ns / 1ps

// escaped frame receiver with crc-32 check
// in channel: in_valid / in_ready carry one raw link byte (rx_byte) per beat
// out channel: out_valid / out_ready carry one de-escaped packet byte per beat,
//   with its position, packet_end, crc_match and the good / bad packet counts
// escape_code is written through cfg_write / cfg_data; the user must write it
// only while the block is idle, and the block itself does not enforce this. a
// byte is captured in the input register at accept, decoded and crc-updated as it
// leaves, and its result lands in the output register. one byte per cycle is
// sustained while out_ready stays high; the byte-wide crc update is the
// combinational path that sets it. a lone escape beat produces no output beat
// when out_ready stays low the output register holds its beat, one more byte
// waits in the input register, then in_ready drops until the output drains
// reset clears both registers, the packet position, crc and counters, and
// restores escape_code to 126

module escaped_frame_receiver_crc32_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [7:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] data_byte,
  output logic [7:0] byte_position,
  output logic packet_end,
  output logic crc_match,
  output logic [15:0] good_packets,
  output logic [15:0] bad_packets
);

  logic in_full;
  logic [7:0] in_byte;
  logic advance;
  logic emit;
  efr_pkg::result_t result;
  efr_pkg::result_t out_reg;

  assign advance = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  efr_deframer u_deframer (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .step(advance),
    .rx_byte(in_byte),
    .emit(emit),
    .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_reg <= result;
    end
  end

  assign data_byte = out_reg.data_byte;
  assign byte_position = out_reg.byte_position;
  assign packet_end = out_reg.packet_end;
  assign crc_match = out_reg.crc_match;
  assign good_packets = out_reg.good_packets;
  assign bad_packets = out_reg.bad_packets;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input stalled with room downstream");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_byte))
    else $error("waiting input byte lost");

  a_no_emit_no_beat: assert property (@(posedge clk) disable iff (rst)
    advance && !emit |=> !out_valid)
    else $error("output beat for a lone escape");

endmodule
